// ===== design/tpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder: register
// indexes, pixel depths, packet codes and the result word layout.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] C_IDX_RLE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] C_IDX_BPP          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] C_IDX_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] C_IDX_IMAGE_HEIGHT = 2'd3;

    // Pixel depths
    localparam logic [5:0] C_BPP_16    = 6'd16;
    localparam logic [5:0] C_BPP_24    = 6'd24;
    localparam logic [5:0] C_BPP_32    = 6'd32;
    localparam logic [5:0] C_BPP_RESET = C_BPP_24;

    // Bytes per pixel for each depth
    localparam logic [2:0] C_NBYTES_16 = 3'd2;
    localparam logic [2:0] C_NBYTES_24 = 3'd3;
    localparam logic [2:0] C_NBYTES_32 = 3'd4;

    // RLE packet header codes
    localparam logic [7:0] C_RUN_THRESHOLD = 8'd128;
    localparam logic [7:0] C_RUN_BIAS      = 8'd127;

    // Mask of one 5-5-5 colour field
    localparam logic [4:0] C_FIELD5_MASK = 5'h1f;

    // Configuration seen by the decode stage
    typedef struct packed {
        logic       rle_mode;
        logic [5:0] bits_per_pixel;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       has_alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
        logic       format_error;
    } t_out_word;

endpackage

// ===== design/tpsd_in_if.sv =====
// ----------------------------------------------------------------------------
// tpsd_in_if
// Byte channel into the decoder: one data byte and the start-of-image flag.
// ----------------------------------------------------------------------------
interface tpsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_image;

    modport source (output valid, output data_byte, output start_image, input ready);
    modport sink   (input valid, input data_byte, input start_image, output ready);
endinterface

// ===== design/tpsd_out_if.sv =====
// ----------------------------------------------------------------------------
// tpsd_out_if
// Pixel record channel out of the decoder: colour, repeat count and flags.
// ----------------------------------------------------------------------------
interface tpsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic       format_error;

    modport source (
        output valid, output red, output green, output blue, output alpha,
        output has_alpha, output repeat_count, output last_pixel,
        output format_error, input ready
    );
    modport sink (
        input valid, input red, input green, input blue, input alpha,
        input has_alpha, input repeat_count, input last_pixel,
        input format_error, output ready
    );
endinterface

// ===== design/tga_pixel_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_core
// Decodes the pixel data bytes of a TGA image (raw at 16/24/32 bit, RLE at 24/32 bit)
// into colour records with repeat counts.
// ----------------------------------------------------------------------------
//   channel     dir  handshake      word
//   i_in_chan   in   valid/ready    data_byte, start_image
//   o_out_chan  out  valid/ready    red..format_error
//   i_cfg_*     in   write enable   register index, data
//
// One byte per cycle while the output is not stalled; a byte's record passes
// through the input register, the decode logic and the result register,
// and the decode logic updates its packet state once per accepted byte.
// Reset clears the packet state and restores the register defaults.
// A stalled result holds in the output register while one more byte waits
// in the input register.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_core #(
    parameter int DIM_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tpsd_in_if.sink                         i_in_chan,
    tpsd_out_if.source                      o_out_chan
);

    tpsd_pkg::t_cfg        w_cfg;
    logic [2*DIM_BITS-1:0] w_total;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_start;

    logic                  r_out_valid;
    tpsd_pkg::t_out_word   r_out_word;

    logic                  w_advance;
    logic                  w_step;
    logic                  w_res_valid;
    tpsd_pkg::t_out_word   w_res;

    tpsd_cfg_regs #(
        .DIM_BITS (DIM_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_total    (w_total)
    );

    // Move on when the result slot is free or being emptied
    assign w_advance       = !r_out_valid || o_out_chan.ready;
    assign w_step          = r_in_valid && w_advance;
    assign i_in_chan.ready = !r_in_valid || w_advance;

    // Hold the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_chan.valid && i_in_chan.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_chan.valid && i_in_chan.ready) begin
            r_in_byte  <= i_in_chan.data_byte;
            r_in_start <= i_in_chan.start_image;
        end
    end

    tpsd_decode #(
        .DIM_BITS (DIM_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_cfg       (w_cfg),
        .i_total     (w_total),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Register the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_chan.valid        = r_out_valid;
    assign o_out_chan.red          = r_out_word.red;
    assign o_out_chan.green        = r_out_word.green;
    assign o_out_chan.blue         = r_out_word.blue;
    assign o_out_chan.alpha        = r_out_word.alpha;
    assign o_out_chan.has_alpha    = r_out_word.has_alpha;
    assign o_out_chan.repeat_count = r_out_word.repeat_count;
    assign o_out_chan.last_pixel   = r_out_word.last_pixel;
    assign o_out_chan.format_error = r_out_word.format_error;

    // An error word carries no colour and no count
    a_error_word_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.format_error) |->
            (r_out_word.repeat_count == 8'd0 && r_out_word.red == 8'd0
             && r_out_word.has_alpha == 1'b0 && r_out_word.last_pixel == 1'b0))
        else $error("error word carries pixel data");

    // A stalled result word holds until taken
    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out_chan.ready) |=> (r_out_valid && $stable(r_out_word)))
        else $error("output word changed during stall");

    // A byte held in the input register is not lost while the result stalls
    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input word lost during stall");

endmodule

// ===== design/tpsd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tpsd_cfg_regs
// Header registers written through the plain write port, and the registered
// pixel total (width times height, each from the low DIM_BITS bits of the data).
// ----------------------------------------------------------------------------
module tpsd_cfg_regs #(
    parameter int DIM_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tpsd_pkg::t_cfg                   o_cfg,
    output logic [2*DIM_BITS-1:0]            o_total
);

    logic                r_rle_mode;
    logic [5:0]          r_bpp;
    logic [DIM_BITS-1:0] r_width;
    logic [DIM_BITS-1:0] r_height;
    logic [2*DIM_BITS-1:0] r_total;

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode <= 1'b0;
            r_bpp      <= tpsd_pkg::C_BPP_RESET;
            r_width    <= '0;
            r_height   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpsd_pkg::C_IDX_RLE_MODE:     r_rle_mode <= i_cfg_data[0];
                tpsd_pkg::C_IDX_BPP:          r_bpp      <= i_cfg_data[5:0];
                tpsd_pkg::C_IDX_IMAGE_WIDTH:  r_width    <= i_cfg_data[DIM_BITS-1:0];
                tpsd_pkg::C_IDX_IMAGE_HEIGHT: r_height   <= i_cfg_data[DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register the pixel total in the cycle after the dimensions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= {{DIM_BITS{1'b0}}, r_width} * {{DIM_BITS{1'b0}}, r_height};
        end
    end

    assign o_cfg.rle_mode       = r_rle_mode;
    assign o_cfg.bits_per_pixel = r_bpp;
    assign o_total              = r_total;

endmodule

// ===== design/tpsd_decode.sv =====
// ----------------------------------------------------------------------------
// tpsd_decode
// Packet and pixel state of the image, updated once per byte, and the
// combinational decode of one byte into an optional result word.
// ----------------------------------------------------------------------------
module tpsd_decode #(
    parameter int DIM_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic                   i_start,
    input  tpsd_pkg::t_cfg         i_cfg,
    input  logic [2*DIM_BITS-1:0]  i_total,
    output logic                   o_res_valid,
    output tpsd_pkg::t_out_word    o_res
);

    localparam int TOT_W = 2 * DIM_BITS;

    // Packet and image state
    logic             r_eph, n_eph;
    logic [1:0]       r_bip, n_bip;
    logic [23:0]      r_gath, n_gath;
    logic             r_is_run, n_is_run;
    logic [7:0]       r_pleft, n_pleft;
    logic [TOT_W-1:0] r_done, n_done;
    logic             r_fin, n_fin;

    // State as seen by this byte, after an optional start clear
    logic             c_eph, c_is_run, c_fin;
    logic [1:0]       c_bip;
    logic [23:0]      c_gath;
    logic [7:0]       c_pleft;
    logic [TOT_W-1:0] c_done;

    logic             fmt_ok;
    logic [2:0]       nbytes;
    logic [15:0]      px16;
    logic [7:0]       count;
    logic [TOT_W-1:0] remaining;
    logic [TOT_W-1:0] done_sum;

    // Decode one byte
    always_comb begin
        c_eph    = i_start ? 1'b1 : r_eph;
        c_bip    = i_start ? 2'd0 : r_bip;
        c_gath   = i_start ? 24'd0 : r_gath;
        c_is_run = i_start ? 1'b0 : r_is_run;
        c_pleft  = i_start ? 8'd0 : r_pleft;
        c_done   = i_start ? '0 : r_done;
        c_fin    = i_start ? 1'b0 : r_fin;

        n_eph    = c_eph;
        n_bip    = c_bip;
        n_gath   = c_gath;
        n_is_run = c_is_run;
        n_pleft  = c_pleft;
        n_done   = c_done;
        n_fin    = c_fin;

        o_res_valid = 1'b0;
        o_res       = '0;

        fmt_ok = (i_cfg.bits_per_pixel == tpsd_pkg::C_BPP_24)
              || (i_cfg.bits_per_pixel == tpsd_pkg::C_BPP_32)
              || ((i_cfg.bits_per_pixel == tpsd_pkg::C_BPP_16) && !i_cfg.rle_mode);

        case (i_cfg.bits_per_pixel)
            tpsd_pkg::C_BPP_16: nbytes = tpsd_pkg::C_NBYTES_16;
            tpsd_pkg::C_BPP_32: nbytes = tpsd_pkg::C_NBYTES_32;
            default:            nbytes = tpsd_pkg::C_NBYTES_24;
        endcase

        px16      = {i_byte, c_gath[7:0]};
        count     = 8'd1;
        remaining = i_total - c_done;
        done_sum  = '0;

        if (c_fin) begin
            // drop bytes after the last pixel
        end else if (i_total == '0) begin
            n_fin = 1'b1;
        end else if (!fmt_ok) begin
            // one error word, then the image is over
            o_res_valid        = 1'b1;
            o_res.format_error = 1'b1;
            n_fin              = 1'b1;
        end else if (i_cfg.rle_mode && c_eph) begin
            // packet header: raw below the threshold, run otherwise
            if (i_byte < tpsd_pkg::C_RUN_THRESHOLD) begin
                n_is_run = 1'b0;
                n_pleft  = i_byte + 8'd1;
            end else begin
                n_is_run = 1'b1;
                n_pleft  = i_byte - tpsd_pkg::C_RUN_BIAS;
            end
            n_eph = 1'b0;
        end else if ({1'b0, c_bip} + 3'd1 < nbytes) begin
            // gather an early byte of the pixel
            case (c_bip)
                2'd0:    n_gath = {c_gath[23:8], i_byte};
                2'd1:    n_gath = {c_gath[23:16], i_byte, c_gath[7:0]};
                default: n_gath = {i_byte, c_gath[15:0]};
            endcase
            n_bip = c_bip + 2'd1;
        end else begin
            // last byte of the pixel: build the colour
            o_res_valid = 1'b1;
            case (nbytes)
                tpsd_pkg::C_NBYTES_16: begin
                    o_res.blue  = {px16[4:0] & tpsd_pkg::C_FIELD5_MASK, 3'b000};
                    o_res.green = {px16[9:5] & tpsd_pkg::C_FIELD5_MASK, 3'b000};
                    o_res.red   = {px16[14:10] & tpsd_pkg::C_FIELD5_MASK, 3'b000};
                end
                tpsd_pkg::C_NBYTES_32: begin
                    o_res.blue      = c_gath[7:0];
                    o_res.green     = c_gath[15:8];
                    o_res.red       = c_gath[23:16];
                    o_res.alpha     = i_byte;
                    o_res.has_alpha = 1'b1;
                end
                default: begin
                    o_res.blue  = c_gath[7:0];
                    o_res.green = c_gath[15:8];
                    o_res.red   = i_byte;
                end
            endcase
            n_bip  = 2'd0;
            n_gath = 24'd0;

            // advance the packet
            if (i_cfg.rle_mode) begin
                if (c_is_run) begin
                    count   = (c_pleft != 8'd0) ? c_pleft : 8'd1;
                    n_pleft = 8'd0;
                    n_eph   = 1'b1;
                end else if (c_pleft <= 8'd1) begin
                    n_pleft = 8'd0;
                    n_eph   = 1'b1;
                end else begin
                    n_pleft = c_pleft - 8'd1;
                end
            end

            // cut the record at the end of the image
            if ({{(TOT_W-8){1'b0}}, count} > remaining) begin
                count = remaining[7:0];
            end
            done_sum = c_done + {{(TOT_W-8){1'b0}}, count};
            n_done   = done_sum;
            if (done_sum >= i_total) begin
                n_fin = 1'b1;
            end
            o_res.repeat_count = count;
            o_res.last_pixel   = n_fin;
        end
    end

    // Hold state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eph    <= 1'b1;
            r_bip    <= 2'd0;
            r_gath   <= 24'd0;
            r_is_run <= 1'b0;
            r_pleft  <= 8'd0;
            r_done   <= '0;
            r_fin    <= 1'b0;
        end else if (i_step) begin
            r_eph    <= n_eph;
            r_bip    <= n_bip;
            r_gath   <= n_gath;
            r_is_run <= n_is_run;
            r_pleft  <= n_pleft;
            r_done   <= n_done;
            r_fin    <= n_fin;
        end
    end

endmodule
